FILE: rtl/linear_probe_hash_table_assert.svh
// assertion macros shared by the checker
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;
  localparam status_t ST_BAD  = 2'd3;

endpackage

FILE: rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lpht_mod.sv
module lpht_mod #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] rem
);
  import lpht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int RW = 32;
  localparam int PW = KEY_W + RW;
  localparam int SH = KEY_W + AW;
  localparam longint unsigned RECIP = (64'd1 << SH) / SLOTS;
  localparam logic [RW-1:0] RECIP_W = RW'(RECIP);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_BACK = 2'd2;
  localparam logic [1:0] M_FIX  = 2'd3;

  logic [1:0]       stg_r, stg_nxt;
  logic             done_r, done_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] q_r, q_nxt;
  logic [KEY_W-1:0] qd_r, qd_nxt;
  logic [AW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] diff;

  // reciprocal quotient estimate is low by at most one, so one subtract fixes it
  assign prod = PW'(key_r) * PW'(RECIP_W);
  assign diff = key_r - qd_r;

  always_comb begin
    stg_nxt  = stg_r;
    done_nxt = 1'b0;
    key_nxt  = key_r;
    q_nxt    = q_r;
    qd_nxt   = qd_r;
    rem_nxt  = rem_r;
    case (stg_r)
      M_IDLE: begin
        if (start) begin
          key_nxt = key;
          stg_nxt = M_MUL;
        end
      end
      M_MUL: begin
        q_nxt   = KEY_W'(prod >> SH);
        stg_nxt = M_BACK;
      end
      M_BACK: begin
        qd_nxt  = q_r * KEY_W'(SLOTS);
        stg_nxt = M_FIX;
      end
      M_FIX: begin
        rem_nxt  = (diff >= KEY_W'(SLOTS)) ? AW'(diff - KEY_W'(SLOTS)) : AW'(diff);
        done_nxt = 1'b1;
        stg_nxt  = M_IDLE;
      end
      default: begin
        stg_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      stg_r  <= stg_nxt;
      done_r <= done_nxt;
    end
    key_r <= key_nxt;
    q_r   <= q_nxt;
    qd_r  <= qd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// flow: a rejected request (bad key or mode, full insert, miss on empty table) goes
//   straight to the result state S_FIN; a probing request passes through S_PROBE first,
//   after the home-slot reduction in S_MOD if SLOTS is not 2^n
// throughput: one request at a time; each probed slot takes one key-RAM read
//   and one shared compare
// reset: synchronous, active low; a clearing pass then writes every slot empty
//   before the first request is taken
module linear_probe_hash_table #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lpht_pkg::MODE_W-1:0]  in_mode,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lpht_pkg::STAT_W-1:0]  out_status,
  output logic [lpht_pkg::SLOT_W-1:0]  out_slot,
  output logic [lpht_pkg::OCC_W-1:0]   out_occupancy
);
  import lpht_pkg::*;

  localparam int  AW   = $clog2(SLOTS);
  localparam int  CNTW = $clog2(SLOTS + 1);
  localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  mode_t            mode_r, mode_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]    home_r, home_nxt;
  logic [AW-1:0]    paddr_r, paddr_nxt;
  logic             dir_r, dir_nxt;
  logic [CNTW-1:0]  issued_r, issued_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]    caddr_r, caddr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [AW-1:0]    res_slot_r, res_slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;
  logic             mod_start;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;
  logic [KEY_W-1:0] want;
  logic             hit;
  logic             mode_ok;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic [CNTW+OCC_W-1:0] occ_ext;

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (paddr_r),
    .rdata (ram_rdata)
  );

  lpht_mod #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // insert looks for an empty slot, the others for the key
  assign want     = (mode_r == MODE_INSERT) ? '0 : key_r;
  assign hit      = cmp_v_r && (ram_rdata == want);
  assign mode_ok  = (in_mode == MODE_INSERT) || (in_mode == MODE_SEARCH) ||
                    (in_mode == MODE_DELETE);
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_r};
  assign occ_ext  = {{OCC_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    paddr_nxt      = paddr_r;
    dir_nxt        = dir_r;
    issued_nxt     = issued_r;
    cmp_v_nxt      = cmp_v_r;
    caddr_nxt      = caddr_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_occ_nxt    = out_occ_r;
    ram_we         = 1'b0;
    ram_waddr      = caddr_r;
    ram_wdata      = key_r;
    mod_start      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt     = in_mode;
          key_nxt      = in_key;
          res_slot_nxt = '0;
          paddr_nxt    = in_key[AW-1:0];
          home_nxt     = in_key[AW-1:0];
          dir_nxt      = 1'b0;
          issued_nxt   = '0;
          cmp_v_nxt    = 1'b0;
          if (in_key == '0 || !mode_ok) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_FIN;
          end else if (in_mode == MODE_INSERT && count_r == CNTW'(SLOTS)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_FIN;
          end else if (in_mode != MODE_INSERT && count_r == '0) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_FIN;
          end else if (POW2) begin
            state_nxt = S_PROBE;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          home_nxt  = mod_rem;
          paddr_nxt = mod_rem;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit) begin
          res_status_nxt = ST_OK;
          res_slot_nxt   = caddr_r;
          cmp_v_nxt      = 1'b0;
          state_nxt      = S_FIN;
          if (mode_r == MODE_INSERT) begin
            ram_we    = 1'b1;
            ram_wdata = key_r;
            count_nxt = count_r + CNTW'(1);
          end else if (mode_r == MODE_DELETE) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            count_nxt = count_r - CNTW'(1);
          end
        end else begin
          // last slot compared with no match
          if (cmp_v_r && issued_r == CNTW'(SLOTS)) begin
            res_status_nxt = (mode_r == MODE_INSERT) ? ST_FULL : ST_MISS;
            state_nxt      = S_FIN;
          end
          cmp_v_nxt = (issued_r != CNTW'(SLOTS));
          if (issued_r != CNTW'(SLOTS)) begin
            caddr_nxt  = paddr_r;
            issued_nxt = issued_r + CNTW'(1);
            // upward to the top slot, then down from just below home
            if (!dir_r) begin
              if (paddr_r == AW'(SLOTS - 1)) begin
                paddr_nxt = home_r - AW'(1);
                dir_nxt   = 1'b1;
              end else begin
                paddr_nxt = paddr_r + AW'(1);
              end
            end else begin
              paddr_nxt = paddr_r - AW'(1);
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = slot_ext[SLOT_W-1:0];
          out_occ_nxt    = occ_ext[OCC_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      issued_r    <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      issued_r    <= issued_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    paddr_r      <= paddr_nxt;
    caddr_r      <= caddr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_occupancy = out_occ_r;

endmodule

FILE: rtl/lpht_checker.sv
module lpht_checker #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lpht_pkg::STAT_W-1:0] out_status,
  input logic [lpht_pkg::SLOT_W-1:0] out_slot,
  input logic [lpht_pkg::OCC_W-1:0]  out_occupancy
);
  import lpht_pkg::*;

`include "linear_probe_hash_table_assert.svh"

  // a request is in progress, so the next one waits
  `LPHT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "request taken while busy")

  // a failed request never reports a slot
  `LPHT_ASSERT_NOW(a_slot_zero_on_fail, out_valid && out_status != ST_OK, out_slot == '0, "slot set on failure")

  // occupancy can not exceed the table size
  `LPHT_ASSERT_NOW(a_occ_bound, out_valid, (SLOTS > 31) || (int'(out_occupancy) <= SLOTS), "occupancy above table size")

  // a result waiting on the consumer holds
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_slot) && $stable(out_occupancy), "stalled result changed")

endmodule

bind linear_probe_hash_table lpht_checker #(
  .SLOTS (SLOTS)
) u_lpht_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_slot      (out_slot),
  .out_occupancy (out_occupancy)
);
